FILE: rtl/urb_pkg.sv
// package for the serial port byte queue engine: sizes, op codes, pointer helpers
package urb_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned AddrW      = $clog2(QueueDepth);
  localparam int unsigned PtrW       = AddrW + 1;

  typedef enum logic [1:0] {
    OpRead    = 2'd0,
    OpWrite   = 2'd1,
    OpService = 2'd2
  } op_e;

  typedef logic [PtrW-1:0]  ptr_t;
  typedef logic [AddrW-1:0] addr_t;

  typedef struct packed {
    logic rd_hit;
    logic wr_ok;
    logic rx_taken;
    logic tx_sent;
    logic rx_en;
    logic tx_en;
  } flags_t;

  function automatic logic ptr_empty(ptr_t head, ptr_t tail);
    return head == tail;
  endfunction

  function automatic logic ptr_full(ptr_t head, ptr_t tail);
    return (head[PtrW-1] != tail[PtrW-1]) && (head[AddrW-1:0] == tail[AddrW-1:0]);
  endfunction

endpackage

FILE: rtl/urb_if.sv
// valid/ready channel interfaces for request and result words
interface urb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] write_byte;
  logic       data_ready;
  logic [7:0] rx_byte;
  logic       thr_empty;

  modport source (output valid, op, write_byte, data_ready, rx_byte, thr_empty, input ready);
  modport sink   (input valid, op, write_byte, data_ready, rx_byte, thr_empty, output ready);
endinterface

interface urb_rsp_if;
  logic       valid;
  logic       ready;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       write_accepted;
  logic       rx_taken;
  logic       send_valid;
  logic [7:0] send_byte;
  logic       rx_irq_enable;
  logic       tx_irq_enable;

  modport source (output valid, read_valid, read_byte, write_accepted, rx_taken, send_valid,
                  send_byte, rx_irq_enable, tx_irq_enable, input ready);
  modport sink   (input valid, read_valid, read_byte, write_accepted, rx_taken, send_valid,
                  send_byte, rx_irq_enable, tx_irq_enable, output ready);
endinterface

FILE: rtl/uart_rx_tx_ring_buffer_engine.sv
// receive and transmit byte rings between software and a serial port, with irq enables
//
// req_i carries one word per item: a software read (pop a received byte), a software
// write (push a byte to send) or a service event with the port's data-ready flag,
// receive byte and transmit-empty flag. rsp_o returns exactly one result word per item.
// Both rings live in 64 x 8 synchronous memories with a registered read.
// An accepted item updates pointers and enables and issues its memory read and write
// at its accept edge; the popped byte is registered there and the result word is loaded
// into the output register on the first edge at which that register is free or taken,
// after which the result is visible on rsp_o until it is taken.
// Throughput is one item per cycle while rsp_o does not stall: the stage after the
// memory read and the output register each hold one word and move together.
// When rsp_o stalls, the output register and the stage behind it hold their words and
// req_i.ready falls once both are full; nothing is lost.
// After reset both rings are empty, the receive enable is one and the transmit enable
// is zero; ring contents are undefined but only written entries are ever popped.
module uart_rx_tx_ring_buffer_engine (
  input  logic     clk_i,
  input  logic     rst_ni,
  urb_req_if.sink   req_i,
  urb_rsp_if.source rsp_o
);

  logic [7:0] rx_mem [urb_pkg::QueueDepth];
  logic [7:0] tx_mem [urb_pkg::QueueDepth];

  urb_pkg::ptr_t rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  urb_pkg::ptr_t tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic          rx_en_q, rx_en_d, tx_en_q, tx_en_d;

  urb_pkg::op_e  op;
  urb_pkg::flags_t flags_d, flags_q;
  logic          accept, advance;
  logic          pipe_q;
  logic          rx_we, tx_we, rx_re, tx_re;
  logic [7:0]    rx_rdata_q, tx_rdata_q;

  logic          out_valid_q;
  logic          read_valid_q, write_accepted_q, rx_taken_q, send_valid_q;
  logic [7:0]    read_byte_q, send_byte_q;
  logic          rx_irq_q, tx_irq_q;

  assign op      = urb_pkg::op_e'(req_i.op);
  assign advance = pipe_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !pipe_q || advance;
  assign accept  = req_i.valid && req_i.ready;

  // next pointers, enables and result flags
  always_comb begin
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    rx_en_d   = rx_en_q;
    tx_en_d   = tx_en_q;
    flags_d   = '0;
    rx_we     = 1'b0;
    tx_we     = 1'b0;
    rx_re     = 1'b0;
    tx_re     = 1'b0;
    if (accept) begin
      unique case (op)
        urb_pkg::OpRead: begin
          if (!urb_pkg::ptr_empty(rx_head_q, rx_tail_q)) begin
            flags_d.rd_hit = 1'b1;
            rx_re          = 1'b1;
            rx_head_d      = rx_head_q + 1'b1;
          end
          rx_en_d = 1'b1;
        end
        urb_pkg::OpWrite: begin
          if (!urb_pkg::ptr_full(tx_head_q, tx_tail_q)) begin
            flags_d.wr_ok = 1'b1;
            tx_we         = 1'b1;
            tx_tail_d     = tx_tail_q + 1'b1;
            tx_en_d       = 1'b1;
          end
        end
        urb_pkg::OpService: begin
          if (req_i.data_ready) begin
            if (!urb_pkg::ptr_full(rx_head_q, rx_tail_q)) begin
              flags_d.rx_taken = 1'b1;
              rx_we            = 1'b1;
              rx_tail_d        = rx_tail_q + 1'b1;
            end else begin
              rx_en_d = 1'b0;
            end
          end
          if (req_i.thr_empty) begin
            if (!urb_pkg::ptr_empty(tx_head_q, tx_tail_q)) begin
              flags_d.tx_sent = 1'b1;
              tx_re           = 1'b1;
              tx_head_d       = tx_head_q + 1'b1;
            end else begin
              tx_en_d = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
    flags_d.rx_en = rx_en_d;
    flags_d.tx_en = tx_en_d;
  end

  // ring memories
  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_tail_q[urb_pkg::AddrW-1:0]] <= req_i.rx_byte;
    end
    if (rx_re) begin
      rx_rdata_q <= rx_mem[rx_head_q[urb_pkg::AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_tail_q[urb_pkg::AddrW-1:0]] <= req_i.write_byte;
    end
    if (tx_re) begin
      tx_rdata_q <= tx_mem[tx_head_q[urb_pkg::AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      rx_en_q   <= 1'b1;
      tx_en_q   <= 1'b0;
      pipe_q    <= 1'b0;
    end else begin
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      rx_en_q   <= rx_en_d;
      tx_en_q   <= tx_en_d;
      if (accept) begin
        pipe_q <= 1'b1;
      end else if (advance) begin
        pipe_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q <= flags_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      read_valid_q     <= flags_q.rd_hit;
      read_byte_q      <= flags_q.rd_hit ? rx_rdata_q : 8'h00;
      write_accepted_q <= flags_q.wr_ok;
      rx_taken_q       <= flags_q.rx_taken;
      send_valid_q     <= flags_q.tx_sent;
      send_byte_q      <= flags_q.tx_sent ? tx_rdata_q : 8'h00;
      rx_irq_q         <= flags_q.rx_en;
      tx_irq_q         <= flags_q.tx_en;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.read_valid     = read_valid_q;
  assign rsp_o.read_byte      = read_byte_q;
  assign rsp_o.write_accepted = write_accepted_q;
  assign rsp_o.rx_taken       = rx_taken_q;
  assign rsp_o.send_valid     = send_valid_q;
  assign rsp_o.send_byte      = send_byte_q;
  assign rsp_o.rx_irq_enable  = rx_irq_q;
  assign rsp_o.tx_irq_enable  = tx_irq_q;

  // checks
  rx_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    urb_pkg::ptr_t'(rx_tail_q - rx_head_q) <= urb_pkg::ptr_t'(urb_pkg::QueueDepth))
    else $error("receive ring overfilled");

  tx_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    urb_pkg::ptr_t'(tx_tail_q - tx_head_q) <= urb_pkg::ptr_t'(urb_pkg::QueueDepth))
    else $error("transmit ring overfilled");

  one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !((rsp_o.read_valid || rsp_o.write_accepted) &&
                      (rsp_o.rx_taken || rsp_o.send_valid)))
    else $error("result mixes item kinds");

  accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pipe_q)
    else $error("accepted word not held in stage");

endmodule
